### design/pksw_pkg.sv
// ----------------------------------------------------------------------------
// pksw_pkg: shared types and constants for the per-key sliding window limiter
// Holds the register map and the queue entry between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
package pksw_pkg;
   localparam int KeyWidth   = 32;
   localparam int TimeWidth  = 32;
   localparam int WinWidth   = 12;
   localparam int LimitWidth = 5;
   localparam int CsrAddrWidth = 3;

   localparam logic [CsrAddrWidth-1:0] CSR_WINDOW = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_LIMIT  = 3'd4;

   localparam logic [WinWidth-1:0]   WINDOW_RESET = 12'd60;
   localparam logic [LimitWidth-1:0] LIMIT_RESET  = 5'd20;

   typedef struct packed {
      logic [KeyWidth-1:0]  key;
      logic [TimeWidth-1:0] now;
   } req_item_type;
endpackage
`default_nettype wire

### design/pksw_queue.sv
// ----------------------------------------------------------------------------
// pksw_queue: two-entry request queue between front and back
// Decouples input acceptance from table processing.
// ----------------------------------------------------------------------------
`default_nettype none
module pksw_queue
   import pksw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire req_item_type in_item,
   output logic              out_valid,
   input  wire logic         out_pop,
   output req_item_type      out_item
);
   req_item_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_pop && out_valid;

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end
endmodule
`default_nettype wire

### design/pksw_engine.sv
// ----------------------------------------------------------------------------
// pksw_engine: table search, stamp compaction and result register
// Walks the key/count tables, then compacts one entry's stamps.
// ----------------------------------------------------------------------------
`default_nettype none
module pksw_engine
   import pksw_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 256,
   parameter int STAMPS_PER_ENTRY = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   output logic                       item_pop,
   input  wire req_item_type          item,
   input  wire logic [WinWidth-1:0]   window_seconds,
   input  wire logic [LimitWidth-1:0] request_limit,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_limited,
   output logic [LimitWidth-1:0]      rsp_recent_count
);
   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = (STAMPS_PER_ENTRY > 1) ? $clog2(STAMPS_PER_ENTRY) : 1;
   localparam int CW = $clog2(STAMPS_PER_ENTRY + 1);
   localparam int CLW = (CW > LimitWidth) ? CW : LimitWidth;
   localparam int AW = EW + SW;
   localparam int ECW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_SCAN = 7'b0000100,
      S_SETUP = 7'b0001000, S_RD = 7'b0010000, S_CMP = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [KeyWidth-1:0] key_mem [TABLE_ENTRIES];
   logic [CW-1:0]       cnt_mem [TABLE_ENTRIES];
   logic [TimeWidth-1:0] stamp_mem [TABLE_ENTRIES*STAMPS_PER_ENTRY];

   logic [ECW-1:0] idx_ff;
   logic [EW-1:0]  hit_ff, free_ff, ent_ff;
   logic           hit_ok_ff, free_ok_ff;
   logic [KeyWidth-1:0] key_rd_ff;
   logic [CW-1:0]  cnt_rd_ff, n_ff, rd_i_ff, kept_ff;
   logic [TimeWidth-1:0] stamp_rd_ff;
   logic           out_valid_ff, out_lim_ff;
   logic [LimitWidth-1:0] out_cnt_ff;
   logic           rd_phase_ff;
   logic [CLW-1:0] lim_c;
   logic [TimeWidth-1:0] age;
   logic [AW-1:0]  base;
   logic           refuse;

   assign rsp_valid        = out_valid_ff;
   assign rsp_limited      = out_lim_ff;
   assign rsp_recent_count = out_cnt_ff;
   assign item_pop         = (state_ff == S_DONE) && !out_valid_ff;

   always_comb begin
      if (CLW'(request_limit) > CLW'(STAMPS_PER_ENTRY)) lim_c = CLW'(STAMPS_PER_ENTRY);
      else lim_c = CLW'(request_limit);
      age    = item.now - stamp_rd_ff;
      base   = AW'(ent_ff) * AW'(STAMPS_PER_ENTRY);
      refuse = (CLW'(kept_ff) >= lim_c);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (idx_ff == ECW'(TABLE_ENTRIES - 1)) state_in = S_IDLE;
         S_IDLE:  if (item_valid) state_in = S_SCAN;
         S_SCAN:  if (rd_phase_ff && idx_ff == ECW'(TABLE_ENTRIES)) state_in = S_SETUP;
         S_SETUP: state_in = S_RD;
         S_RD:    state_in = (rd_i_ff == n_ff) ? S_DONE : S_CMP;
         S_CMP:   state_in = S_RD;
         S_DONE:  if (!out_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         rd_phase_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               cnt_mem[idx_ff[EW-1:0]] <= '0;
               if (idx_ff == ECW'(TABLE_ENTRIES - 1)) idx_ff <= '0;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_IDLE: begin
               idx_ff      <= '0;
               rd_phase_ff <= 1'b0;
               hit_ok_ff   <= 1'b0;
               free_ok_ff  <= 1'b0;
            end
            S_SCAN: begin
               // pipeline: read entry idx, evaluate previous read
               if (rd_phase_ff) begin
                  if (cnt_rd_ff != '0 && key_rd_ff == item.key && !hit_ok_ff) begin
                     hit_ok_ff <= 1'b1;
                     hit_ff    <= EW'(idx_ff - 1'b1);
                  end
                  if (cnt_rd_ff == '0 && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff    <= EW'(idx_ff - 1'b1);
                  end
               end
               if (idx_ff != ECW'(TABLE_ENTRIES)) begin
                  key_rd_ff <= key_mem[idx_ff[EW-1:0]];
                  cnt_rd_ff <= cnt_mem[idx_ff[EW-1:0]];
                  idx_ff    <= idx_ff + 1'b1;
                  rd_phase_ff <= 1'b1;
               end
            end
            S_SETUP: begin
               // hit keeps count; free slot and eviction start empty
               if (hit_ok_ff) begin
                  ent_ff <= hit_ff;
                  n_ff   <= cnt_mem[hit_ff];
               end else begin
                  ent_ff <= free_ok_ff ? free_ff : '0;
                  n_ff   <= '0;
               end
               rd_i_ff <= '0;
               kept_ff <= '0;
            end
            S_RD: begin
               if (rd_i_ff != n_ff) begin
                  stamp_rd_ff <= stamp_mem[base + AW'(rd_i_ff)];
                  rd_i_ff     <= rd_i_ff + 1'b1;
               end else begin
                  key_mem[ent_ff] <= item.key;
                  if (refuse) begin
                     cnt_mem[ent_ff] <= kept_ff;
                  end else begin
                     stamp_mem[base + AW'(kept_ff)] <= item.now;
                     cnt_mem[ent_ff] <= kept_ff + 1'b1;
                  end
               end
            end
            S_CMP: begin
               if (age < TimeWidth'(window_seconds)) begin
                  stamp_mem[base + AW'(kept_ff)] <= stamp_rd_ff;
                  kept_ff <= kept_ff + 1'b1;
               end
            end
            S_DONE: begin
               // load the result only once the previous one has left
               if (!out_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  out_lim_ff   <= refuse;
                  out_cnt_ff   <= refuse ? LimitWidth'(kept_ff)
                                         : LimitWidth'(kept_ff + 1'b1);
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### design/per_key_sliding_window_limiter_core.sv
// ----------------------------------------------------------------------------
// per_key_sliding_window_limiter_core: per-key sliding window rate limiter
// Admits or refuses each request based on its key's recent request times.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    requester_key, current_time
// rsp      out        rsp_valid/stall    limited, recent_count
// csr      in/out     APB psel/penable   window_seconds, request_limit
//
// A request in the engine first sweeps the key/count table one entry per
// cycle, then reads each of the entry's stamps and compacts them through the
// single-port stamp memory, with a read state and a compare state per stamp.
// After reset a clearing pass zeroes the counts; requests queue meanwhile.
// A two-entry queue holds requests while the engine works; a stalled
// result holds the engine in its final state.
// ----------------------------------------------------------------------------
`default_nettype none
module per_key_sliding_window_limiter_core
   import pksw_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 256,
   parameter int STAMPS_PER_ENTRY = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [KeyWidth-1:0]     req_requester_key,
   input  wire logic [TimeWidth-1:0]    req_current_time,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_limited,
   output logic [LimitWidth-1:0]        rsp_recent_count,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   logic [WinWidth-1:0]   window_ff;
   logic [LimitWidth-1:0] limit_ff;
   req_item_type          in_item, q_item;
   logic                  q_valid, q_pop;

   assign csr_pready = 1'b1;

   // Hold register values; write on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            CSR_WINDOW: window_ff <= csr_pwdata[WinWidth-1:0];
            CSR_LIMIT:  limit_ff  <= csr_pwdata[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_WINDOW: csr_prdata = {{(32-WinWidth){1'b0}}, window_ff};
         CSR_LIMIT:  csr_prdata = {{(32-LimitWidth){1'b0}}, limit_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign in_item.key = req_requester_key;
   assign in_item.now = req_current_time;

   // Front: accept requests into the queue.
   pksw_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_item(in_item),
      .out_valid(q_valid), .out_pop(q_pop), .out_item(q_item)
   );

   // Back: search, compact, decide.
   pksw_engine #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .STAMPS_PER_ENTRY(STAMPS_PER_ENTRY)
   ) u_engine (
      .clock, .reset,
      .item_valid(q_valid), .item_pop(q_pop), .item(q_item),
      .window_seconds(window_ff), .request_limit(limit_ff),
      .rsp_valid, .rsp_stall, .rsp_limited, .rsp_recent_count
   );
endmodule
`default_nettype wire
